// ===== rtl/mkag_pkg.sv =====
// mkag_pkg: shared types, constants and helper functions for the midi keyed audio gate
// no dependencies; used by every module in rtl/

package mkag_pkg;

    // field widths
    localparam int SAMPLE_W    = 24;
    localparam int GAIN_FRAC   = 16;
    localparam int GATE_W      = GAIN_FRAC + 1;        // gate level holds 0 .. unity
    localparam int GAIN_W      = GATE_W + 1;           // total gain, may exceed unity
    localparam int HOLD_W      = 20;
    localparam int COUNT_W     = 8;
    localparam int STEP_W      = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // shared multiplier
    localparam int MUL_A_W     = SAMPLE_W + 1;
    localparam int MUL_B_W     = GAIN_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int CUT_PROD_W  = 2 * GATE_W;

    localparam logic [GATE_W-1:0] GATE_ONE  = GATE_W'(1) << GAIN_FRAC;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // register reset values
    localparam logic [STEP_W-1:0] ATTACK_RST   = STEP_W'(656);
    localparam logic [STEP_W-1:0] DECAY_RST    = STEP_W'(66);
    localparam logic [HOLD_W-1:0] HOLD_RST     = HOLD_W'(4800);
    localparam logic [GATE_W-1:0] CUT_RST      = '0;
    localparam logic              BYPASS_RST   = 1'b0;
    localparam logic              INIT_DIR_RST = 1'b0;

    // midi status high nibbles
    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
    localparam logic [3:0] MIDI_PROGRAM  = 4'hC;

    // item kinds
    localparam logic ITEM_SAMPLE = 1'b0;
    localparam logic ITEM_MIDI   = 1'b1;

    // reported gate codes
    localparam logic [1:0] GATE_CODE_SHUT = 2'd0;
    localparam logic [1:0] GATE_CODE_HOLD = 2'd1;
    localparam logic [1:0] GATE_CODE_OPEN = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ATTACK_STEP = 3'd0,
        REG_DECAY_STEP  = 3'd1,
        REG_HOLD        = 3'd2,
        REG_CUT_GAIN    = 3'd3,
        REG_BYPASS      = 3'd4,
        REG_INIT_DIR    = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_CLOSED  = 3'd0,
        PH_OPENING = 3'd1,
        PH_OPEN    = 3'd2,
        PH_HOLD    = 3'd3,
        PH_CLOSING = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_CUT,
        ST_GAIN,
        ST_MUL_LEFT,
        ST_MUL_RIGHT,
        ST_WRITE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_CUT,
        MUL_LEFT,
        MUL_RIGHT
    } mul_sel_t;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic [7:0]                 midi_status;
        logic [6:0]                 midi_data;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_gated;
        logic signed [SAMPLE_W-1:0] right_gated;
        logic [1:0]                 gate_code;
    } out_item_t;

    typedef struct packed {
        logic [STEP_W-1:0] attack_step;
        logic [STEP_W-1:0] decay_step;
        logic [HOLD_W-1:0] hold_samples;
        logic [GATE_W-1:0] cut_gain;
        logic              bypass;
        logic              initial_direction;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     load_gain;
        logic     load_left;
        logic     load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_midi;
        logic bypass;
    } dp_status_t;

    // round half up after the gain product, then clamp to the sample range
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]             q;
        logic [PROD_W-SAMPLE_W-GAIN_FRAC:0]   top;
        logic [SAMPLE_W-1:0]                  res;
        q   = p + PROD_W'(1 << (GAIN_FRAC - 1));
        top = q[PROD_W-1:SAMPLE_W+GAIN_FRAC-1];
        if ((top == '0) || (top == '1))
        begin
            res = q[SAMPLE_W+GAIN_FRAC-1:GAIN_FRAC];
        end
        else if (q[PROD_W-1])
        begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== rtl/midi_keyed_audio_gate.sv =====
// midi keyed audio gate: a midi message is taken while idle and gives no result; a sample pair has
// its result registered after the cut product, gain, left, right and write steps (write only when
// bypassed), set by one 25x19 multiplier shared for the cut gain product and the two channel products
// one item at a time: a midi message per cycle while idle; a sample pair stalls input until written
// reset (rst_n low, async): gate closed at level 0, hold and note count 0, direction 0,
// registers to their defaults, no result pending

module midi_keyed_audio_gate (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel: midi messages and stereo sample pairs
    input  logic                               item_valid,
    output logic                               item_stall,
    input  mkag_pkg::in_item_t                 item,
    // result channel: one result per sample pair
    output logic                               result_valid,
    input  logic                               result_stall,
    output mkag_pkg::out_item_t                result,
    // register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mkag_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mkag_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mkag_pkg::cfg_t       cfg;
    mkag_pkg::dp_cmd_t    cmd;
    mkag_pkg::dp_status_t status;

    // register file; the user must write only while the gate is idle, the block does not enforce it
    mkag_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: idle -> cut product -> gain -> left product -> right product -> write (bypass: idle -> write)
    // midi messages finish in the idle cycle that takes them
    mkag_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // gate state, note count, shared multiplier and the result register
    // the result register lets the next item transfer while a result still waits
    mkag_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // a sample pair keeps the sequencer busy in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.cmd == mkag_pkg::ITEM_SAMPLE)) |=> item_stall)
        else $error("sequencer did not start on a sample transfer");

    // a midi message completes in the cycle that takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.cmd == mkag_pkg::ITEM_MIDI)) |=> !item_stall)
        else $error("midi transfer left the sequencer busy");

    // a new result only comes out of the write step of a busy sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without a sample in flight");

    // the decoded command never loads the result register outside of a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid || !result_stall))
        else $error("result register overwritten while stalled");

endmodule

// ===== rtl/mkag_cfg.sv =====
// mkag_cfg: configuration register file written through the cfg channel
// depends on mkag_pkg

module mkag_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mkag_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mkag_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mkag_pkg::cfg_t                     cfg
);

    mkag_pkg::cfg_t cfg_reg;
    mkag_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                mkag_pkg::REG_ATTACK_STEP: cfg_next.attack_step  = cfg_data[mkag_pkg::STEP_W-1:0];
                mkag_pkg::REG_DECAY_STEP:  cfg_next.decay_step   = cfg_data[mkag_pkg::STEP_W-1:0];
                mkag_pkg::REG_HOLD:        cfg_next.hold_samples = cfg_data[mkag_pkg::HOLD_W-1:0];
                mkag_pkg::REG_CUT_GAIN:    cfg_next.cut_gain     = cfg_data[mkag_pkg::GATE_W-1:0];
                mkag_pkg::REG_BYPASS:      cfg_next.bypass       = cfg_data[0];
                mkag_pkg::REG_INIT_DIR:    cfg_next.initial_direction = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step       <= mkag_pkg::ATTACK_RST;
            cfg_reg.decay_step        <= mkag_pkg::DECAY_RST;
            cfg_reg.hold_samples      <= mkag_pkg::HOLD_RST;
            cfg_reg.cut_gain          <= mkag_pkg::CUT_RST;
            cfg_reg.bypass            <= mkag_pkg::BYPASS_RST;
            cfg_reg.initial_direction <= mkag_pkg::INIT_DIR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/mkag_ctrl.sv =====
// mkag_ctrl: sequencing state machine and output valid for the gate
// depends on mkag_pkg; drives mkag_dp through dp_cmd_t

module mkag_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  mkag_pkg::dp_status_t   status,
    output mkag_pkg::dp_cmd_t      cmd
);

    mkag_pkg::ctrl_state_t state_reg;
    mkag_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != mkag_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = mkag_pkg::MUL_CUT;
        cmd.load_gain = 1'b0;
        cmd.load_left = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            mkag_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.is_midi)
                    begin
                        state_next = status.bypass ? mkag_pkg::ST_WRITE : mkag_pkg::ST_MUL_CUT;
                    end
                end
            end
            mkag_pkg::ST_MUL_CUT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mkag_pkg::MUL_CUT;
                state_next  = mkag_pkg::ST_GAIN;
            end
            mkag_pkg::ST_GAIN:
            begin
                cmd.load_gain = 1'b1;
                state_next    = mkag_pkg::ST_MUL_LEFT;
            end
            mkag_pkg::ST_MUL_LEFT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mkag_pkg::MUL_LEFT;
                state_next  = mkag_pkg::ST_MUL_RIGHT;
            end
            mkag_pkg::ST_MUL_RIGHT:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = mkag_pkg::MUL_RIGHT;
                cmd.load_left = 1'b1;
                state_next    = mkag_pkg::ST_WRITE;
            end
            mkag_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mkag_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mkag_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mkag_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/mkag_dp.sv =====
// mkag_dp: gate state, midi note tracking, shared gain multiplier and result register
// depends on mkag_pkg; commanded by mkag_ctrl

module mkag_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mkag_pkg::in_item_t     item,
    input  mkag_pkg::cfg_t         cfg,
    input  mkag_pkg::dp_cmd_t      cmd,
    output mkag_pkg::dp_status_t   status,
    output mkag_pkg::out_item_t    result
);

    // gate state
    mkag_pkg::phase_t                     phase_reg, phase_next;
    logic [mkag_pkg::GATE_W-1:0]          gate_reg, gate_next;
    logic [mkag_pkg::HOLD_W-1:0]          hold_reg, hold_next;
    logic [mkag_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic                                 dir_reg, dir_next;

    // payload
    logic signed [mkag_pkg::SAMPLE_W-1:0] left_reg, right_reg;
    logic signed [mkag_pkg::PROD_W-1:0]   prod_reg;
    logic [mkag_pkg::GAIN_W-1:0]          gain_reg;
    logic [mkag_pkg::SAMPLE_W-1:0]        left_res_reg;
    mkag_pkg::out_item_t                  result_reg;

    logic                                 active;
    logic [mkag_pkg::STEP_W-1:0]          a_step, d_step;
    logic [mkag_pkg::GATE_W:0]            open_sum;
    logic signed [mkag_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [mkag_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [mkag_pkg::PROD_W-1:0]   prod_next;
    logic [mkag_pkg::CUT_PROD_W-1:0]      cut_rnd;
    logic [mkag_pkg::GAIN_W-1:0]          gain_next;
    logic [1:0]                           code;

    assign status.is_midi = (item.cmd == mkag_pkg::ITEM_MIDI);
    assign status.bypass  = cfg.bypass;
    assign result         = result_reg;

    assign active   = dir_reg ? (count_reg == '0) : (count_reg != '0);
    assign a_step   = (cfg.attack_step == '0) ? mkag_pkg::STEP_W'(1) : cfg.attack_step;
    assign d_step   = (cfg.decay_step == '0) ? mkag_pkg::STEP_W'(1) : cfg.decay_step;
    assign open_sum = {1'b0, gate_reg} + {1'b0, a_step};

    // note tracking and per-sample phase machine
    always_comb
    begin
        phase_next = phase_reg;
        gate_next  = gate_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        dir_next   = dir_reg;
        if (cmd.accept && (item.cmd == mkag_pkg::ITEM_MIDI))
        begin
            if (!cfg.bypass)
            begin
                case (item.midi_status[7:4])
                    mkag_pkg::MIDI_NOTE_ON:
                    begin
                        if (count_reg != mkag_pkg::COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    mkag_pkg::MIDI_NOTE_OFF:
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    mkag_pkg::MIDI_PROGRAM:
                    begin
                        if (item.midi_data[6:1] == '0)
                        begin
                            phase_next = mkag_pkg::PH_CLOSED;
                            gate_next  = '0;
                            hold_next  = '0;
                            count_next = '0;
                            dir_next   = item.midi_data[0];
                        end
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
        end
        else if (cmd.accept)
        begin
            case (phase_reg)
                mkag_pkg::PH_CLOSED:
                begin
                    if (active)
                    begin
                        phase_next = mkag_pkg::PH_OPENING;
                    end
                end
                mkag_pkg::PH_OPENING:
                begin
                    if (open_sum >= {1'b0, mkag_pkg::GATE_ONE})
                    begin
                        gate_next  = mkag_pkg::GATE_ONE;
                        phase_next = mkag_pkg::PH_OPEN;
                    end
                    else
                    begin
                        gate_next = open_sum[mkag_pkg::GATE_W-1:0];
                    end
                end
                mkag_pkg::PH_OPEN:
                begin
                    if (!active)
                    begin
                        phase_next = mkag_pkg::PH_HOLD;
                        hold_next  = cfg.hold_samples;
                    end
                end
                mkag_pkg::PH_HOLD:
                begin
                    if (active)
                    begin
                        phase_next = mkag_pkg::PH_OPEN;
                    end
                    else if (hold_reg == '0)
                    begin
                        phase_next = mkag_pkg::PH_CLOSING;
                    end
                    else
                    begin
                        hold_next = hold_reg - 1'b1;
                    end
                end
                mkag_pkg::PH_CLOSING:
                begin
                    gate_next = (gate_reg > d_step) ? (gate_reg - d_step) : '0;
                    if (active)
                    begin
                        phase_next = mkag_pkg::PH_OPENING;
                    end
                    else if (gate_next == '0)
                    begin
                        phase_next = mkag_pkg::PH_CLOSED;
                    end
                end
                default:
                begin
                    phase_next = mkag_pkg::PH_CLOSED;
                end
            endcase
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            mkag_pkg::MUL_CUT:
            begin
                mul_a = $signed({{(mkag_pkg::MUL_A_W-mkag_pkg::GATE_W){1'b0}}, cfg.cut_gain});
                mul_b = $signed({{(mkag_pkg::MUL_B_W-mkag_pkg::GATE_W){1'b0}},
                                 mkag_pkg::GATE_ONE - gate_reg});
            end
            mkag_pkg::MUL_LEFT:
            begin
                mul_a = {left_reg[mkag_pkg::SAMPLE_W-1], left_reg};
                mul_b = $signed({1'b0, gain_reg});
            end
            mkag_pkg::MUL_RIGHT:
            begin
                mul_a = {right_reg[mkag_pkg::SAMPLE_W-1], right_reg};
                mul_b = $signed({1'b0, gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // gain = gate + round(cut * (1 - gate))
    assign cut_rnd   = prod_reg[mkag_pkg::CUT_PROD_W-1:0]
                     + mkag_pkg::CUT_PROD_W'(1 << (mkag_pkg::GAIN_FRAC - 1));
    assign gain_next = {1'b0, gate_reg} + cut_rnd[mkag_pkg::CUT_PROD_W-1:mkag_pkg::GAIN_FRAC];

    always_comb
    begin
        case (phase_reg)
            mkag_pkg::PH_OPEN: code = mkag_pkg::GATE_CODE_OPEN;
            mkag_pkg::PH_HOLD: code = mkag_pkg::GATE_CODE_HOLD;
            default:           code = mkag_pkg::GATE_CODE_SHUT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mkag_pkg::PH_CLOSED;
            gate_reg  <= '0;
            hold_reg  <= '0;
            count_reg <= '0;
            dir_reg   <= mkag_pkg::INIT_DIR_RST;
        end
        else
        begin
            phase_reg <= phase_next;
            gate_reg  <= gate_next;
            hold_reg  <= hold_next;
            count_reg <= count_next;
            dir_reg   <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            left_reg  <= item.left_in;
            right_reg <= item.right_sample;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load_gain)
        begin
            gain_reg <= gain_next;
        end
        if (cmd.load_left)
        begin
            left_res_reg <= mkag_pkg::round_sat(prod_reg);
        end
        if (cmd.load_out)
        begin
            result_reg.left_gated  <= cfg.bypass ? left_reg : $signed(left_res_reg);
            result_reg.right_gated <= cfg.bypass ? right_reg
                                                 : $signed(mkag_pkg::round_sat(prod_reg));
            result_reg.gate_code   <= code;
        end
    end

endmodule

// ===== sim/tb_midi_keyed_audio_gate.sv =====
// tb_midi_keyed_audio_gate: self-checking testbench for the midi keyed audio gate
// depends on rtl/mkag_pkg.sv (item, result and register types) and the gate top level
`timescale 1ns / 100ps

module tb_midi_keyed_audio_gate;

    // sizing of the run
    localparam int UNITY         = 65536;          // q16 gate fully open
    localparam longint SMP_MAX   = 64'sd8388607;
    localparam longint SMP_MIN   = -64'sd8388608;
    localparam int RST_CYCLES    = 12;
    localparam int SETTLE        = 10;
    localparam int LONG_HOLD     = 300;            // receiver hold-off in cycles
    localparam int PER_PHASE     = 115;
    localparam int NUM_PHASES    = 9;
    localparam int SAT_RUN       = 262;            // note-ons to hit the count ceiling
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_MAX    = 10;

    // register indexes past the end of the list, the block must ignore them
    localparam logic [mkag_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [mkag_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // power-on register values
    localparam int ATTACK_POR = 656;
    localparam int DECAY_POR  = 66;
    localparam int HOLD_POR   = 4800;

    // clock and every block input start at known values
    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 item_valid   = 1'b0;
    logic                                 item_stall;
    mkag_pkg::in_item_t                   item         = '0;
    logic                                 result_valid;
    logic                                 result_stall = 1'b0;
    mkag_pkg::out_item_t                  result;
    logic                                 cfg_valid    = 1'b0;
    logic                                 cfg_ready;
    logic [mkag_pkg::CFG_INDEX_W-1:0]     cfg_index    = '0;
    logic [mkag_pkg::CFG_DATA_W-1:0]      cfg_data     = '0;

    // shared controls between the driving processes
    bit  quiet         = 1'b0;     // no idling on either side while set
    bit  hold_off_req  = 1'b0;     // asks the receiver for one long hold-off
    int  n_sent        = 0;
    int  n_settings    = 0;
    int  n_cycles      = 0;

    // gate predictor and expected-result store
    class gate_scoreboard;
        mkag_pkg::cfg_t                 regs;
        mkag_pkg::phase_t               phase;
        int unsigned                    gate_level;
        int unsigned                    hold_left;
        logic [mkag_pkg::COUNT_W-1:0]   note_count;
        logic                           direction;
        mkag_pkg::out_item_t            expected_q[$];
        int                             mismatches;
        int                             checked;
        int                             open_seen;
        int                             hold_seen;

        function new();
            regs.attack_step       = mkag_pkg::STEP_W'(ATTACK_POR);
            regs.decay_step        = mkag_pkg::STEP_W'(DECAY_POR);
            regs.hold_samples      = mkag_pkg::HOLD_W'(HOLD_POR);
            regs.cut_gain          = '0;
            regs.bypass            = 1'b0;
            regs.initial_direction = 1'b0;
            clear_gate();
            direction  = 1'b0;
            mismatches = 0;
            checked    = 0;
            open_seen  = 0;
            hold_seen  = 0;
        endfunction

        function void clear_gate();
            phase      = mkag_pkg::PH_CLOSED;
            gate_level = 0;
            hold_left  = 0;
            note_count = '0;
        endfunction

        // direction keeps its reset value, writing initial_direction does not change it
        function void apply_reg(logic [mkag_pkg::CFG_INDEX_W-1:0] idx,
                                logic [mkag_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                mkag_pkg::REG_ATTACK_STEP: regs.attack_step       = val[mkag_pkg::STEP_W-1:0];
                mkag_pkg::REG_DECAY_STEP:  regs.decay_step        = val[mkag_pkg::STEP_W-1:0];
                mkag_pkg::REG_HOLD:        regs.hold_samples      = val[mkag_pkg::HOLD_W-1:0];
                mkag_pkg::REG_CUT_GAIN:    regs.cut_gain          = val[mkag_pkg::GATE_W-1:0];
                mkag_pkg::REG_BYPASS:      regs.bypass            = val[0];
                mkag_pkg::REG_INIT_DIR:    regs.initial_direction = val[0];
                default: ;
            endcase
        endfunction

        // q16 gain, round half up, clamp to 24 bits
        function logic [mkag_pkg::SAMPLE_W-1:0] scale(longint s, longint g);
            longint q;
            q = (s * g + 64'sd32768) >>> mkag_pkg::GAIN_FRAC;
            if (q > SMP_MAX)
                q = SMP_MAX;
            else if (q < SMP_MIN)
                q = SMP_MIN;
            return q[mkag_pkg::SAMPLE_W-1:0];
        endfunction

        function void note_item(mkag_pkg::in_item_t it);
            bit                  active;
            int unsigned         up;
            int unsigned         down;
            longint              cp;
            longint              g;
            mkag_pkg::out_item_t want;
            if (it.cmd == mkag_pkg::ITEM_MIDI)
            begin
                if (regs.bypass)
                    return;
                case (it.midi_status[7:4])
                    mkag_pkg::MIDI_NOTE_ON:
                        if (note_count != mkag_pkg::COUNT_MAX) note_count++;
                    mkag_pkg::MIDI_NOTE_OFF:
                        if (note_count != 0) note_count--;
                    mkag_pkg::MIDI_PROGRAM:
                    begin
                        if (it.midi_data <= 7'd1)
                        begin
                            clear_gate();
                            direction = it.midi_data[0];
                        end
                    end
                    default: ;
                endcase
                return;
            end

            active = direction ? (note_count == 0) : (note_count != 0);
            up     = (regs.attack_step == 0) ? 1 : regs.attack_step;
            down   = (regs.decay_step == 0) ? 1 : regs.decay_step;

            case (phase)
                mkag_pkg::PH_CLOSED:
                    if (active) phase = mkag_pkg::PH_OPENING;
                mkag_pkg::PH_OPENING:
                begin
                    gate_level += up;
                    if (gate_level >= UNITY)
                    begin
                        gate_level = UNITY;
                        phase      = mkag_pkg::PH_OPEN;
                    end
                end
                mkag_pkg::PH_OPEN:
                begin
                    if (!active)
                    begin
                        phase     = mkag_pkg::PH_HOLD;
                        hold_left = regs.hold_samples;
                    end
                end
                mkag_pkg::PH_HOLD:
                begin
                    if (active)
                        phase = mkag_pkg::PH_OPEN;
                    else if (hold_left == 0)
                        phase = mkag_pkg::PH_CLOSING;
                    else
                        hold_left--;
                end
                mkag_pkg::PH_CLOSING:
                begin
                    gate_level = (gate_level > down) ? gate_level - down : 0;
                    if (active)
                        phase = mkag_pkg::PH_OPENING;
                    else if (gate_level == 0)
                        phase = mkag_pkg::PH_CLOSED;
                end
                default:
                    phase = mkag_pkg::PH_CLOSED;
            endcase

            want.left_gated  = it.left_in;
            want.right_gated = it.right_sample;
            if (!regs.bypass)
            begin
                cp = longint'(regs.cut_gain) * longint'(UNITY - gate_level);
                g  = longint'(gate_level) + ((cp + 64'sd32768) >>> mkag_pkg::GAIN_FRAC);
                want.left_gated  = scale(longint'($signed(it.left_in)), g);
                want.right_gated = scale(longint'($signed(it.right_sample)), g);
            end
            if (phase == mkag_pkg::PH_OPEN)
            begin
                want.gate_code = mkag_pkg::GATE_CODE_OPEN;
                open_seen++;
            end
            else if (phase == mkag_pkg::PH_HOLD)
            begin
                want.gate_code = mkag_pkg::GATE_CODE_HOLD;
                hold_seen++;
            end
            else
                want.gate_code = mkag_pkg::GATE_CODE_SHUT;
            expected_q.push_back(want);
        endfunction

        function void flag(string what, mkag_pkg::out_item_t want, mkag_pkg::out_item_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s: expected l=%h r=%h code=%0d, got l=%h r=%h code=%0d",
                         $realtime, what, want.left_gated, want.right_gated, want.gate_code,
                         got.left_gated, got.right_gated, got.gate_code);
        endfunction

        function void check_result(mkag_pkg::out_item_t got);
            mkag_pkg::out_item_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                flag("result with nothing outstanding", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.left_gated !== want.left_gated || got.right_gated !== want.right_gated ||
                got.gate_code !== want.gate_code)
                flag("result mismatch", want, got);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    gate_scoreboard board;

    midi_keyed_audio_gate DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("tb_midi_keyed_audio_gate failed");
            $finish;
        end
    end

    // monitor: every transfer is seen here, on pre-edge values
    // register writes first, then input transfers, then results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.apply_reg(cfg_index, cfg_data);
            if (item_valid && !item_stall)
                board.note_item(item);
            if (result_valid && !result_stall)
                board.check_result(result);
        end
    end

    // idle cycles before the next item or result, none in quiet stretches
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // receiver: random stall before each result, plus one long hold-off on request
    initial
    begin
        int n;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                // the block fills up behind this and must stall its input
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            n = draw_gap();
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------
    // item builders, unused fields carry random bits
    // ---------------------------------------------------------------
    function automatic mkag_pkg::in_item_t mk_sample(logic [mkag_pkg::SAMPLE_W-1:0] l,
                                                     logic [mkag_pkg::SAMPLE_W-1:0] r);
        mkag_pkg::in_item_t it;
        it.cmd          = mkag_pkg::ITEM_SAMPLE;
        it.left_in      = l;
        it.right_sample = r;
        it.midi_status  = 8'($urandom);
        it.midi_data    = 7'($urandom);
        return it;
    endfunction

    function automatic mkag_pkg::in_item_t mk_midi(logic [7:0] status, logic [6:0] data);
        mkag_pkg::in_item_t it;
        it.cmd          = mkag_pkg::ITEM_MIDI;
        it.left_in      = mkag_pkg::SAMPLE_W'($urandom);
        it.right_sample = mkag_pkg::SAMPLE_W'($urandom);
        it.midi_status  = status;
        it.midi_data    = data;
        return it;
    endfunction

    // sample values lean toward the extremes or toward zero now and then
    function automatic logic [mkag_pkg::SAMPLE_W-1:0] rnd_smp();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return mkag_pkg::SAMPLE_W'($urandom_range(0, 255)) - 24'd128;
            default: return mkag_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic mkag_pkg::in_item_t rnd_pair();
        return mk_sample(rnd_smp(), rnd_smp());
    endfunction

    // mostly steep ramps so that the machine runs through all its phases
    function automatic int unsigned rnd_step();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, UNITY);
        return $urandom_range(8000, UNITY);
    endfunction

    function automatic mkag_pkg::cfg_t pick_settings(int p);
        mkag_pkg::cfg_t c;
        c.attack_step       = mkag_pkg::STEP_W'(rnd_step());
        c.decay_step        = mkag_pkg::STEP_W'(rnd_step());
        c.hold_samples      = ($urandom_range(0, 3) == 0) ? mkag_pkg::HOLD_W'($urandom) :
                              mkag_pkg::HOLD_W'($urandom_range(0, 12));
        c.cut_gain          = mkag_pkg::GATE_W'($urandom_range(0, 17'h1FFFF));
        c.bypass            = ($urandom_range(0, 4) == 0);
        c.initial_direction = 1'($urandom);
        case (p)
            0:  c = '{attack_step: 17'd30000, decay_step: 17'd30000, hold_samples: 20'd2,
                      cut_gain: 17'd16384, bypass: 1'b0, initial_direction: 1'b0};
            // zero steps behave as one
            1:  c = '{attack_step: 17'd0, decay_step: 17'd0, hold_samples: 20'd0,
                      cut_gain: 17'd0, bypass: 1'b0, initial_direction: 1'b1};
            // unity steps and cut gain, single-sample ramps
            2:  c = '{attack_step: 17'd65536, decay_step: 17'd65536, hold_samples: 20'd0,
                      cut_gain: 17'd65536, bypass: 1'b0, initial_direction: 1'b0};
            // step, hold and cut fields at their top, cut gain near 2 saturates outputs
            3:  c = '{attack_step: 17'h1FFFF, decay_step: 17'h1FFFF, hold_samples: 20'hFFFFF,
                      cut_gain: 17'h1FFFF, bypass: 1'b0, initial_direction: 1'b1};
            4:  c.bypass = 1'b1;
            6:  c.bypass = 1'b0;    // the count ceiling run needs midi to act
            default: ;
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------
    // driving tasks
    // ---------------------------------------------------------------

    // offer one item and hold it until its transfer
    task automatic send_item(mkag_pkg::in_item_t it);
        int n;
        n = draw_gap();
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        n_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // idle block: no result due and the last midi message worked off
    task automatic drain();
        wait_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write, valid is left high for a following write
    task automatic cfg_write(logic [mkag_pkg::CFG_INDEX_W-1:0] idx,
                             logic [mkag_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_regs(mkag_pkg::cfg_t c, bit stray);
        cfg_write(mkag_pkg::REG_ATTACK_STEP, mkag_pkg::CFG_DATA_W'(c.attack_step));
        cfg_write(mkag_pkg::REG_DECAY_STEP, mkag_pkg::CFG_DATA_W'(c.decay_step));
        cfg_write(mkag_pkg::REG_HOLD, mkag_pkg::CFG_DATA_W'(c.hold_samples));
        cfg_write(mkag_pkg::REG_CUT_GAIN, mkag_pkg::CFG_DATA_W'(c.cut_gain));
        cfg_write(mkag_pkg::REG_BYPASS, mkag_pkg::CFG_DATA_W'(c.bypass));
        cfg_write(mkag_pkg::REG_INIT_DIR, mkag_pkg::CFG_DATA_W'(c.initial_direction));
        if (stray)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      mkag_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // hand-picked walk through the phase machine, with attack/decay 30000 and hold 2
    task automatic directed();
        send_item(mk_midi({mkag_pkg::MIDI_PROGRAM, 4'h0}, 7'd0));   // clear, note keying
        send_item(mk_sample(24'h7FFFFF, 24'h800000));                // closed, cut gain only
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_OFF, 4'h0}, 7'd0));  // count already zero
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_ON, 4'hF}, 7'd127));
        send_item(mk_sample(24'h800000, 24'h7FFFFF));                // closed to opening
        send_item(mk_sample(24'h000001, 24'hFFFFFF));
        send_item(rnd_pair());
        send_item(rnd_pair());                                       // opening clamps at unity
        send_item(mk_midi(8'h00, 7'd1));                             // data byte, ignored
        send_item(mk_midi({mkag_pkg::MIDI_PROGRAM, 4'h2}, 7'd127)); // program past 1, ignored
        send_item(mk_midi(8'hFF, 7'd0));                             // system status, ignored
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_OFF, 4'hF}, 7'd1));  // never a program change
        send_item(rnd_pair());                                       // open to hold
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_ON, 4'h0}, 7'd0));
        send_item(rnd_pair());                                       // hold back to open
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_OFF, 4'h5}, 7'd60));
        repeat (4) send_item(rnd_pair());                            // hold counts down, closing
        send_item(rnd_pair());
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_ON, 4'h1}, 7'd64));
        send_item(rnd_pair());                                       // key wins over closing
        send_item(mk_midi({mkag_pkg::MIDI_PROGRAM, 4'h0}, 7'd1));   // clear, open with no notes
        send_item(mk_sample(24'h000000, 24'h000000));
        send_item(mk_midi({mkag_pkg::MIDI_PROGRAM, 4'hF}, 7'd0));   // back to note keying
        send_item(mk_sample(24'h7FFFFF, 24'h7FFFFF));
    endtask

    // one note held over a few pairs, released, then a few more pairs
    task automatic keyed_burst();
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_ON, 4'($urandom)}, 7'($urandom)));
        repeat ($urandom_range(1, 12)) send_item(rnd_pair());
        send_item(mk_midi({mkag_pkg::MIDI_NOTE_OFF, 4'($urandom)}, 7'($urandom)));
        repeat ($urandom_range(1, 12)) send_item(rnd_pair());
    endtask

    task automatic random_items(int n, bit pause_midway);
        int stop;
        int half;
        int k;
        stop = n_sent + n;
        half = n_sent + n / 2;
        while (n_sent < stop)
        begin
            if (pause_midway && n_sent >= half)
            begin
                // sender holds back until the block has nothing left to deliver
                wait_results();
                pause_midway = 1'b0;
            end
            k = $urandom_range(0, 19);
            if (k < 11)
                keyed_burst();
            else if (k < 13)
            begin
                send_item(mk_midi({mkag_pkg::MIDI_PROGRAM, 4'($urandom)},
                                  7'($urandom_range(0, 1))));
                repeat ($urandom_range(1, 6)) send_item(rnd_pair());
            end
            else if (k < 15)
                send_item(rnd_pair());
            else if (k < 17)
                send_item(mk_midi(8'($urandom), 7'($urandom)));
            else if (k == 17)
                send_item(mk_midi({mkag_pkg::MIDI_NOTE_OFF, 4'($urandom)}, 7'($urandom)));
            else if (k == 18)
                send_item(mk_midi({mkag_pkg::MIDI_PROGRAM, 4'($urandom)},
                                  7'($urandom_range(2, 127))));
            else
                send_item(mk_midi({mkag_pkg::MIDI_NOTE_ON, 4'($urandom)}, 7'($urandom)));
        end
    endtask

    // count runs into its ceiling, then back down past zero
    task automatic count_limits();
        repeat (SAT_RUN)
            send_item(mk_midi({mkag_pkg::MIDI_NOTE_ON, 4'($urandom)}, 7'($urandom)));
        repeat (4) send_item(rnd_pair());
        repeat (SAT_RUN)
            send_item(mk_midi({mkag_pkg::MIDI_NOTE_OFF, 4'($urandom)}, 7'($urandom)));
        repeat (8) send_item(rnd_pair());
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        mkag_pkg::cfg_t c;
        board = new();
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a short stretch on the power-on settings
        random_items(40, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            c = pick_settings(p);
            program_regs(c, (p % 3) == 1);
            quiet = ((p % 4) == 3);
            if (p == 0)
                directed();
            if (p == 2)
                hold_off_req = 1'b1;
            if (p == 6)
                count_limits();
            random_items(PER_PHASE, p == 5);
        end

        drain();
        $display("sent %0d items over %0d register settings, checked %0d sample results",
                 n_sent, n_settings, board.checked);
        $display("expected open on %0d results and hold on %0d, %0d mismatches",
                 board.open_seen, board.hold_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_midi_keyed_audio_gate passed");
        else
            $display("tb_midi_keyed_audio_gate failed");
        $finish;
    end

endmodule
